// File: hdl/vcs_pkg.sv
// ----------------------------------------------------------------------------
// vcs_pkg: shared types and constants for the streaming 3x3 convolution
// Field widths, register codes, config struct and coefficient selection.
// ----------------------------------------------------------------------------
package vcs_pkg;

  // field widths
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ROWSUM_W   = 34;
  localparam int SUM_W      = 36;
  localparam int RES_W      = 32;
  localparam int FRAC_SHIFT = 14;

  // kernel geometry
  localparam int KMAX      = 3;
  localparam int TAPS      = KMAX * KMAX;
  localparam int TAP_W     = 4;
  localparam int COEF_BITS = TAPS * COEF_W;

  // config register widths
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int KSIZE_W    = 2;
  localparam int ROW_W      = 12;
  localparam int MAX_ROWS   = 4096;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // defaults
  localparam int DEF_MAX_COLS = 1024;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd8;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd8;
  localparam logic [KSIZE_W-1:0]  RST_KSIZE  = 2'd3;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_WIDTH  = 3'd3,
    REG_COEF_LOW      = 3'd4,
    REG_COEF_MID      = 3'd5,
    REG_COEF_HIGH     = 3'd6
  } cfg_reg_t;

  typedef logic signed [PIX_W-1:0]    pix_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ROWSUM_W-1:0] rowsum_t;

  // clamped frame and kernel geometry
  typedef struct packed {
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    logic [KSIZE_W-1:0]  kh;
    logic [KSIZE_W-1:0]  kw;
  } cfg_t;

  // per item control flags
  typedef struct packed {
    logic emit;
    logic last;
  } flags_t;

  // coefficient of one tap out of the packed coefficient words
  function automatic coef_t coef_pick(input logic [COEF_BITS-1:0] cv,
                                      input logic [TAP_W-1:0] tap);
    coef_t r;
    r = '0;
    for (int t = 0; t < TAPS; t++) begin
      if (tap == TAP_W'(t)) r = cv[COEF_W*t +: COEF_W];
    end
    return r;
  endfunction

endpackage

// File: hdl/vcs_ram.sv
// ----------------------------------------------------------------------------
// vcs_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read, old data on a same address write
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hdl/vcs_pos.sv
// ----------------------------------------------------------------------------
// vcs_pos: raster position counters
// Tracks row and column of the next pixel and flags window completion.
// ----------------------------------------------------------------------------
module vcs_pos import vcs_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  cfg_t                        cfg,
  output logic [$clog2(MAX_COLS)-1:0] col_addr,
  output flags_t                      flags
);

  localparam int COL_W = $clog2(MAX_COLS);

  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;

  // position of the current pixel and of the one after it
  always_comb begin
    logic [WIDTH_W-1:0]  cx, c0, c1;
    logic [HEIGHT_W-1:0] rx, r0, r1;
    cx = WIDTH_W'(col);
    rx = HEIGHT_W'(row);
    // counters past a shrunken limit wrap first
    if (cx >= cfg.w) begin
      c0 = '0;
      r0 = rx + 1'b1;
    end else begin
      c0 = cx;
      r0 = rx;
    end
    if (r0 >= cfg.h) r0 = '0;
    c1 = c0 + 1'b1;
    r1 = r0;
    if (c1 >= cfg.w) begin
      c1 = '0;
      r1 = r0 + 1'b1;
      if (r1 >= cfg.h) r1 = '0;
    end
    col_addr   = COL_W'(c0);
    flags.emit = ((r0 + 1'b1) >= HEIGHT_W'(cfg.kh)) && ((c0 + 1'b1) >= WIDTH_W'(cfg.kw));
    flags.last = (r0 == cfg.h - 1'b1) && (c0 == cfg.w - 1'b1);
    col_next   = COL_W'(c1);
    row_next   = ROW_W'(r1);
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// File: hdl/vcs_mac.sv
// ----------------------------------------------------------------------------
// vcs_mac: window register and tap multipliers
// Shifts the new column into the 3x3 window and registers the nine products.
// ----------------------------------------------------------------------------
module vcs_mac import vcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 s1_valid,
  input  flags_t               s1_flags,
  input  pix_t                 pixel,
  input  logic [2*PIX_W-1:0]   lines,
  input  logic [KSIZE_W-1:0]   kh,
  input  logic [KSIZE_W-1:0]   kw,
  input  logic [COEF_BITS-1:0] coefs,
  output logic                 s2_valid,
  output logic                 s2_last,
  output prod_t                prod [TAPS]
);

  pix_t  win      [KMAX][KMAX];
  pix_t  win_next [KMAX][KMAX];
  prod_t prod_next [TAPS];
  pix_t  col_in   [KMAX];

  // new column: two line store rows on top, the incoming pixel below
  assign col_in[0] = pix_t'(lines[PIX_W-1:0]);
  assign col_in[1] = pix_t'(lines[2*PIX_W-1:PIX_W]);
  assign col_in[2] = pixel;

  // window shifted left by one column
  always_comb begin
    for (int a = 0; a < KMAX; a++) begin
      for (int b = 0; b < KMAX - 1; b++) begin
        win_next[a][b] = win[a][b+1];
      end
      win_next[a][KMAX-1] = col_in[a];
    end
  end

  // kernel sits in the bottom right corner of the window
  always_comb begin
    logic [TAP_W-1:0] tap;
    logic             en;
    for (int a = 0; a < KMAX; a++) begin
      for (int b = 0; b < KMAX; b++) begin
        en  = ((a + int'(kh)) >= KMAX) && ((b + int'(kw)) >= KMAX);
        tap = TAP_W'((a + int'(kh) - KMAX) * KMAX + (b + int'(kw) - KMAX));
        if (en) prod_next[a*KMAX+b] = prod_t'(win_next[a][b]) * prod_t'(coef_pick(coefs, tap));
        else prod_next[a*KMAX+b] = '0;
      end
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < KMAX; a++) begin
        for (int b = 0; b < KMAX; b++) begin
          win[a][b] <= '0;
        end
      end
    end else if (adv && s1_valid) begin
      win <= win_next;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_flags.last;
      prod    <= prod_next;
    end
  end

endmodule

// File: hdl/vcs_sum.sv
// ----------------------------------------------------------------------------
// vcs_sum: product adder tree and result register
// Row sums, final sum with arithmetic shift, and the output item register.
// ----------------------------------------------------------------------------
module vcs_sum import vcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               s2_valid,
  input  logic               s2_last,
  input  prod_t              prod [TAPS],
  output logic               conv_valid,
  output logic signed [RES_W-1:0] conv_value,
  output logic               frame_last
);

  logic    s3_valid;
  logic    s3_last;
  rowsum_t rsum [KMAX];
  logic signed [SUM_W-1:0] total;

  // row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      for (int a = 0; a < KMAX; a++) begin
        rsum[a] <= ROWSUM_W'(prod[a*KMAX]) + ROWSUM_W'(prod[a*KMAX+1])
                 + ROWSUM_W'(prod[a*KMAX+2]);
      end
    end
  end

  // final sum, floor shift right by 14 bits, removing a Q.14 fraction
  assign total = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_valid <= 1'b0;
    end else if (adv) begin
      conv_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      conv_value <= RES_W'(total >>> FRAC_SHIFT);
      frame_last <= s3_last;
    end
  end

endmodule

// File: hdl/valid_conv2d_stream.sv
// ----------------------------------------------------------------------------
// valid_conv2d_stream: streaming valid-region 3x3 cross-correlation
// Pipeline: an accepted pixel item passes the input stage, product stage, row
// sum stage and output register before its result appears on the output.
// Throughput: one pixel item per cycle; the line store RAM is read once and
// written once per item, and an output stall freezes the whole pipeline.
// Reset: counters, window and config registers return to defaults; the line
// store is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module valid_conv2d_stream import vcs_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                    clk,
  input  logic                    rst,
  // pixel channel
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic signed [PIX_W-1:0] pixel,
  // result channel
  output logic                    conv_valid,
  input  logic                    conv_stall,
  output logic signed [RES_W-1:0] conv_value,
  output logic                    frame_last,
  // config channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS);

  // config registers
  logic [WIDTH_W-1:0]    image_width;
  logic [HEIGHT_W-1:0]   image_height;
  logic [KSIZE_W-1:0]    kernel_height;
  logic [KSIZE_W-1:0]    kernel_width;
  logic [CFG_DATA_W-1:0] coef_word_low;
  logic [CFG_DATA_W-1:0] coef_word_mid;
  logic [COEF_W-1:0]     coef_word_high;
  cfg_t                  cfg;

  // pipeline
  logic               adv;
  logic               take;
  logic [COL_W-1:0]   col_addr;
  flags_t             flags;
  logic               s1_valid;
  pix_t               s1_pixel;
  logic [COL_W-1:0]   s1_col;
  flags_t             s1_flags;
  logic               byp;
  logic [2*PIX_W-1:0] byp_data;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] lines;
  logic [2*PIX_W-1:0] ram_wdata;
  logic               ram_we;
  logic               s2_valid;
  logic               s2_last;
  prod_t              prod [TAPS];

  // config write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_WIDTH;
      image_height   <= RST_HEIGHT;
      kernel_height  <= RST_KSIZE;
      kernel_width   <= RST_KSIZE;
      coef_word_low  <= '0;
      coef_word_mid  <= '0;
      coef_word_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width    <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  image_height   <= cfg_data[HEIGHT_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height  <= cfg_data[KSIZE_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width   <= cfg_data[KSIZE_W-1:0];
        REG_COEF_LOW:      coef_word_low  <= cfg_data;
        REG_COEF_MID:      coef_word_mid  <= cfg_data;
        REG_COEF_HIGH:     coef_word_high <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (image_width == '0) cfg.w = WIDTH_W'(1);
    else if (32'(image_width) > MAX_COLS) cfg.w = WIDTH_W'(MAX_COLS);
    else cfg.w = image_width;
    if (image_height == '0) cfg.h = HEIGHT_W'(1);
    else if (32'(image_height) > MAX_ROWS) cfg.h = HEIGHT_W'(MAX_ROWS);
    else cfg.h = image_height;
    cfg.kh = (kernel_height == '0) ? KSIZE_W'(1) : kernel_height;
    cfg.kw = (kernel_width == '0) ? KSIZE_W'(1) : kernel_width;
  end

  // handshake: the pipeline moves unless the result register is held
  assign adv         = !(conv_valid && conv_stall);
  assign pixel_stall = !adv;
  assign take        = pixel_valid && adv;

  vcs_pos #(
    .MAX_COLS (MAX_COLS)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cfg      (cfg),
    .col_addr (col_addr),
    .flags    (flags)
  );

  // line store: {row above, row two above} per column
  vcs_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (col_addr),
    .rdata (ram_rdata)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pixel <= pixel;
      s1_col   <= col_addr;
      s1_flags <= flags;
      // same column written in this cycle: forward the new line data
      byp      <= s1_valid && (s1_col == col_addr);
      byp_data <= ram_wdata;
    end
  end

  // line store update: older row takes the newer, newer takes the pixel
  assign lines     = byp ? byp_data : ram_rdata;
  assign ram_wdata = {s1_pixel, lines[2*PIX_W-1:PIX_W]};
  assign ram_we    = s1_valid && adv;

  vcs_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_flags (s1_flags),
    .pixel    (s1_pixel),
    .lines    (lines),
    .kh       (cfg.kh),
    .kw       (cfg.kw),
    .coefs    ({coef_word_high, coef_word_mid, coef_word_low}),
    .s2_valid (s2_valid),
    .s2_last  (s2_last),
    .prod     (prod)
  );

  vcs_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .s2_valid   (s2_valid),
    .s2_last    (s2_last),
    .prod       (prod),
    .conv_valid (conv_valid),
    .conv_value (conv_value),
    .frame_last (frame_last)
  );

  // accepted item reaches the input stage
  a_take_s1: assert property (@(posedge clk) disable iff (rst)
    take |=> s1_valid)
    else $error("accepted item missing from input stage");

  // line store written only while the pipeline moves
  a_we_adv: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_valid && !pixel_stall))
    else $error("line store written during stall");

  // back to back items on one column use forwarded data
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (take && s1_valid && (s1_col == col_addr)) |=> byp)
    else $error("missing line store forward");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for valid_conv2d_stream
// Streams pixel items through frames of many geometries and coefficient sets.
// A scoreboard model slides its own window and line stores over the same
// items and checks every result, value and frame_last flag, in order.
// ----------------------------------------------------------------------------
module testbench;
  import vcs_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_PCT     = 14;
  localparam int DRAIN_CYCLES = 8;
  localparam pix_t  PIX_MIN  = 16'sh8000;
  localparam pix_t  PIX_MAX  = 16'sh7fff;
  localparam coef_t COEF_MIN = 16'sh8000;
  localparam coef_t COEF_MAX = 16'sh7fff;
  // index past the last register, the block ignores it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    last;
  } conv_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic                    pixel_valid = 1'b0;
  logic                    pixel_stall;
  pix_t                    pixel = '0;
  logic                    conv_valid;
  logic                    conv_stall = 1'b0;
  logic signed [RES_W-1:0] conv_value;
  logic                    frame_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  valid_conv2d_stream uut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .conv_valid  (conv_valid),
    .conv_stall  (conv_stall),
    .conv_value  (conv_value),
    .frame_last  (frame_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // scoreboard copy of the registers
  logic [WIDTH_W-1:0]    reg_width    = RST_WIDTH;
  logic [HEIGHT_W-1:0]   reg_height   = RST_HEIGHT;
  logic [KSIZE_W-1:0]    reg_kh       = RST_KSIZE;
  logic [KSIZE_W-1:0]    reg_kw       = RST_KSIZE;
  logic [CFG_DATA_W-1:0] reg_coef_lo  = '0;
  logic [CFG_DATA_W-1:0] reg_coef_mid = '0;
  coef_t                 reg_coef_hi  = '0;

  // scoreboard copy of the image state
  pix_t        line_mem [KMAX-1][DEF_MAX_COLS] = '{default: '0};
  pix_t        win [KMAX][KMAX] = '{default: '0};
  int unsigned pred_row = 0;
  int unsigned pred_col = 0;

  pix_t         pixel_backlog[$];
  conv_result_t window_sums[$];
  int           idle_pct = IDLE_PCT;
  int           error_count = 0;
  int           random_items = 0;

  function automatic int unsigned clamp_width(input int unsigned w);
    if (w == 0) return 1;
    if (w > DEF_MAX_COLS) return DEF_MAX_COLS;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_ROWS) return MAX_ROWS;
    return reg_height;
  endfunction

  function automatic int unsigned kernel_size(input logic [KSIZE_W-1:0] k);
    return (k == 0) ? 1 : k;
  endfunction

  // tap index is kernel row * 3 + kernel column
  function automatic coef_t tap_coef(input int tap);
    if (tap < 4) return coef_t'(reg_coef_lo[COEF_W*tap +: COEF_W]);
    if (tap < 8) return coef_t'(reg_coef_mid[COEF_W*(tap-4) +: COEF_W]);
    return reg_coef_hi;
  endfunction

  // pixels left before the current frame ends, counting a pending wrap
  function automatic int frame_remaining();
    int unsigned w, h, r, c;
    w = clamp_width(reg_width);
    h = eff_height();
    r = pred_row;
    c = pred_col;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    return w * h - (r * w + c);
  endfunction

  // field value with random junk above its width
  function automatic logic [CFG_DATA_W-1:0] pad_field(input logic [CFG_DATA_W-1:0] v,
                                                      input int bits);
    logic [CFG_DATA_W-1:0] mask, word;
    mask = (64'd1 << bits) - 64'd1;
    word = {$urandom(), $urandom()};
    return (word & ~mask) | (v & mask);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef_word();
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom(), $urandom()};
    case ($urandom_range(3))
      0: for (int t = 0; t < 4; t++) word[COEF_W*t +: COEF_W] = $urandom_range(1) ? COEF_MIN
                                                                                 : COEF_MAX;
      1: for (int t = 0; t < 4; t++) word[COEF_W*t +: COEF_W] = 16'($urandom_range(1023)) - 16'd512;
      default: ;
    endcase
    return word;
  endfunction

  // one pixel through the window: line stores, sum of products, frame position
  task automatic correlate_pixel(input pix_t px);
    int unsigned  w, h, kh, kw, r, c;
    longint       acc;
    conv_result_t res;
    w  = clamp_width(reg_width);
    h  = eff_height();
    kh = kernel_size(reg_kh);
    kw = kernel_size(reg_kw);
    // counters past a lowered limit wrap before the pixel is taken
    if (pred_col >= w) begin
      pred_col = 0;
      pred_row++;
    end
    if (pred_row >= h) pred_row = 0;
    r = pred_row;
    c = pred_col;
    // slide the window left, new column from the line stores and the pixel
    for (int a = 0; a < KMAX; a++)
      for (int b = 0; b < KMAX-1; b++) win[a][b] = win[a][b+1];
    for (int a = 0; a < KMAX-1; a++) win[a][KMAX-1] = line_mem[a][c];
    win[KMAX-1][KMAX-1] = px;
    // age this column of the line stores
    for (int a = 0; a < KMAX-2; a++) line_mem[a][c] = line_mem[a+1][c];
    line_mem[KMAX-2][c] = px;
    // full kernel window: one result, floor shift of the exact sum
    if (r + 1 >= kh && c + 1 >= kw) begin
      acc = 0;
      for (int i = 0; i < kh; i++)
        for (int j = 0; j < kw; j++)
          acc += longint'(win[KMAX-kh+i][KMAX-kw+j]) * longint'(tap_coef(i*KMAX+j));
      res.value = RES_W'(acc >>> FRAC_SHIFT);
      res.last  = (r == h - 1 && c == w - 1);
      window_sums.push_back(res);
    end
    pred_col++;
    if (pred_col >= w) begin
      pred_col = 0;
      pred_row++;
      if (pred_row >= h) pred_row = 0;
    end
  endtask

  // pixel driver: present the next pending item, hold it while stalled
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) correlate_pixel(pixel);
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          pixel       <= pixel_backlog.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random stall, compare against the oldest window sum
  always @(posedge clk) begin : result_monitor
    conv_result_t want;
    if (rst) begin
      conv_stall <= 1'b0;
    end else begin
      if (conv_valid && !conv_stall) begin
        if (window_sums.size() == 0) begin
          $error("conv_value %0d frame_last %0b: no result expected", conv_value, frame_last);
          error_count++;
        end else begin
          want = window_sums.pop_front();
          if (conv_value !== want.value) begin
            $error("conv_value: expected %0d, actual %0d", want.value, conv_value);
            error_count++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0b, actual %0b", want.last, frame_last);
            error_count++;
          end
        end
      end
      conv_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // register write on the config channel, mirrored into the scoreboard
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:   reg_width    = data[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT:  reg_height   = data[HEIGHT_W-1:0];
      REG_KERNEL_HEIGHT: reg_kh       = data[KSIZE_W-1:0];
      REG_KERNEL_WIDTH:  reg_kw       = data[KSIZE_W-1:0];
      REG_COEF_LOW:      reg_coef_lo  = data;
      REG_COEF_MID:      reg_coef_mid = data;
      REG_COEF_HIGH:     reg_coef_hi  = data[COEF_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int kh, input int kw);
    write_reg(REG_IMAGE_WIDTH, pad_field(CFG_DATA_W'(w), WIDTH_W));
    write_reg(REG_IMAGE_HEIGHT, pad_field(CFG_DATA_W'(h), HEIGHT_W));
    write_reg(REG_KERNEL_HEIGHT, pad_field(CFG_DATA_W'(kh), KSIZE_W));
    write_reg(REG_KERNEL_WIDTH, pad_field(CFG_DATA_W'(kw), KSIZE_W));
  endtask

  task automatic set_coefs(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] mid,
                           input logic [CFG_DATA_W-1:0] hi);
    write_reg(REG_COEF_LOW, lo);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_HIGH, pad_field(hi, COEF_W));
  endtask

  // random pixels with the extremes mixed in
  task automatic queue_random_pixels(input int count);
    @(negedge clk);
    repeat (count) begin
      case ($urandom_range(7))
        0: pixel_backlog.push_back(PIX_MIN);
        1: pixel_backlog.push_back(PIX_MAX);
        default: pixel_backlog.push_back(pix_t'($urandom()));
      endcase
    end
  endtask

  // hold off until every item is in and every sum is out, then let the
  // pipeline empty of items that give no result
  task automatic drain();
    int quiet;
    quiet = 0;
    while (pixel_backlog.size() != 0 || pixel_valid || window_sums.size() != 0)
      @(posedge clk);
    while (quiet < DRAIN_CYCLES) begin
      @(posedge clk);
      if (!conv_stall) quiet++;
    end
  endtask

  // one random phase: new geometry and taps, then whole or partial frames
  task automatic random_phase();
    int unsigned w, h, kh, kw;
    int          count, remaining;
    bit          boundary;
    boundary = (pred_row == 0 && pred_col == 0);
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(9))
        0: w = $urandom_range(0, 1);
        1: w = $urandom_range(17, 64);
        default: w = $urandom_range(2, 16);
      endcase
      h  = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
      kh = $urandom_range(0, 3);
      kw = $urandom_range(0, 3);
      // widening mid-frame would read line store columns never filled
      if (!boundary && clamp_width(w) > clamp_width(reg_width)) w = reg_width;
      set_geometry(w, h, kh, kw);
    end
    if ($urandom_range(3) != 0) set_coefs(rand_coef_word(), rand_coef_word(), rand_coef_word());
    remaining = frame_remaining();
    if ($urandom_range(4) == 0)
      count = $urandom_range(1, remaining);
    else
      count = remaining + $urandom_range(0, 1) * clamp_width(reg_width) * eff_height();
    queue_random_pixels(count);
    random_items += count;
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one frame at the reset geometry with the taps still zero
    queue_random_pixels(64);
    drain();

    // 3x3 frame, every tap at the negative extreme, pixels at both extremes
    set_geometry(3, 3, 3, 3);
    set_coefs({4{COEF_MIN}}, {4{COEF_MIN}}, 64'(COEF_MIN));
    @(negedge clk);
    for (int k = 0; k < 9; k++) pixel_backlog.push_back(k[0] ? PIX_MAX : PIX_MIN);
    drain();

    // every tap at the positive extreme against the most negative pixel
    set_coefs({4{COEF_MAX}}, {4{COEF_MAX}}, 64'(COEF_MAX));
    @(negedge clk);
    repeat (9) pixel_backlog.push_back(PIX_MIN);
    drain();

    // zero sizes clamp to a one-pixel frame and a 1x1 kernel; -1 floors to -1
    set_geometry(0, 0, 0, 0);
    write_reg(REG_UNUSED, {$urandom(), $urandom()});
    set_coefs(64'd1, 64'd0, 64'd0);
    @(negedge clk);
    pixel_backlog.push_back(pix_t'(-1));
    pixel_backlog.push_back(pix_t'(1));
    drain();

    // kernel larger than the image: no result at all
    set_geometry(2, 2, 3, 3);
    queue_random_pixels(4);
    drain();

    // random phases, one stretch without any idling, ending on a frame edge
    while (random_items < RANDOM_ITEMS || pred_row != 0 || pred_col != 0) begin
      idle_pct = (random_items >= 150 && random_items < 350) ? 0 : IDLE_PCT;
      random_phase();
    end
    idle_pct = IDLE_PCT;

    // widest row: width field all ones clamps to the column limit
    set_geometry(2047, 1, 1, 3);
    set_coefs(rand_coef_word(), rand_coef_word(), rand_coef_word());
    queue_random_pixels(frame_remaining());
    drain();

    // start of a tall frame: height field all ones must not wrap early
    set_geometry(1, 8191, 3, 1);
    queue_random_pixels(64);
    drain();

    if (error_count == 0)
      $display("valid_conv2d_stream regression: pass");
    else
      $display("valid_conv2d_stream regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("valid_conv2d_stream regression: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/vcs_pkg.sv
hdl/vcs_ram.sv
hdl/vcs_pos.sv
hdl/vcs_mac.sv
hdl/vcs_sum.sv
hdl/valid_conv2d_stream.sv
verif/testbench.sv
